>>> rtl/assert_macros.svh
// Assertion macros for the 6502 executor checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked every clock, off during reset
`define CHK_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("check failed");

// next-cycle implication
`define CHK_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("check failed");

`endif

>>> rtl/m65_pkg.sv
//------------------------------------------------------------------------------
// m65_pkg
// Shared types and constants of the 6502 load/add executor.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

package m65_pkg;

    localparam int MEM_ADDR_BITS_DEF = 16;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_EXEC  = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [7:0] OP_LDA_IMM = 8'hA9;
    localparam logic [7:0] OP_LDA_ZP  = 8'hA5;
    localparam logic [7:0] OP_LDA_ZPX = 8'hB5;
    localparam logic [7:0] OP_LDA_ABS = 8'hAD;
    localparam logic [7:0] OP_LDA_ABX = 8'hBD;
    localparam logic [7:0] OP_LDA_ABY = 8'hB9;
    localparam logic [7:0] OP_LDA_INX = 8'hA1;
    localparam logic [7:0] OP_LDA_INY = 8'hB1;
    localparam logic [7:0] OP_LDX_IMM = 8'hA2;
    localparam logic [7:0] OP_LDX_ZP  = 8'hA6;
    localparam logic [7:0] OP_LDX_ABS = 8'hAE;
    localparam logic [7:0] OP_ADC_IMM = 8'h69;
    localparam logic [7:0] OP_ADC_ZP  = 8'h65;
    localparam logic [7:0] OP_ADC_ABS = 8'h6D;

    localparam logic [0:0] CFG_START = 1'b0;
    localparam logic [0:0] CFG_INDEX_Y = 1'b1;

    // memory address source select
    localparam logic [2:0] AS_PC   = 3'd0;
    localparam logic [2:0] AS_IN   = 3'd1;
    localparam logic [2:0] AS_ZP   = 3'd2;  // tmp low byte, page zero
    localparam logic [2:0] AS_ZP1  = 3'd3;  // tmp low byte + 1, page zero
    localparam logic [2:0] AS_EA   = 3'd4;  // tmp word

    // command from controller to datapath
    typedef struct packed {
        logic       mem_rd;
        logic       mem_wr;
        logic [2:0] addr_sel;
        logic       pc_inc;
        logic       op_load;    // registered read data -> opcode
        logic       lo_load;    // read data -> tmp low
        logic       hi_load;    // read data -> tmp high
        logic       lo_add_x;   // tmp low += x (zero page)
        logic       ea_add_x;   // tmp word += x
        logic       ea_add_y;   // tmp word += y
        logic       exec_wb;    // apply instruction to registers
        logic       rd_cap;     // capture read data for read command
        logic       out_load;   // build result
        logic [2:0] cyc;
        logic       err;
        logic       is_read;
    } m65_cmd_t;

    typedef struct packed {
        logic [7:0] opcode;
        logic       page_x;     // last indexed add crossed a page
    } m65_stat_t;

endpackage

>>> rtl/m65_datapath.sv
//------------------------------------------------------------------------------
// m65_datapath
// Registers, single-port memory, address generation and ALU.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module m65_datapath
    import m65_pkg::*;
#(
    parameter int MEM_ADDR_BITS = MEM_ADDR_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  m65_cmd_t    cmd,
    output m65_stat_t   stat,
    input  logic [15:0] in_address,
    input  logic [7:0]  in_data,
    input  logic        cfg_wr,
    input  logic [0:0]  cfg_idx,
    input  logic [15:0] cfg_val,
    output logic [55:0] result
);

    logic [7:0] mem [0:(1 << MEM_ADDR_BITS) - 1];
    logic [7:0] rdata_reg;

    logic [7:0]  acc_reg, x_reg, flag_reg, y_reg, op_reg;
    logic [15:0] pc_reg, tmp_reg;
    logic        page_reg;
    logic [7:0]  rdv_reg;
    logic [55:0] res_reg;

    logic [15:0] addr;
    logic [16:0] ea_sum;
    logic [7:0]  ld_val;
    logic [8:0]  sum;
    logic [7:0]  nflags;
    logic [7:0]  add_idx;

    always_comb begin
        case (cmd.addr_sel)
            AS_PC:   addr = pc_reg;
            AS_IN:   addr = in_address;
            AS_ZP:   addr = {8'h00, tmp_reg[7:0]};
            AS_ZP1:  addr = {8'h00, tmp_reg[7:0] + 8'd1};
            AS_EA:   addr = tmp_reg;
            default: addr = pc_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.mem_wr) mem[addr[MEM_ADDR_BITS-1:0]] <= in_data;
        if (cmd.mem_rd) rdata_reg <= mem[addr[MEM_ADDR_BITS-1:0]];
    end

    assign add_idx = cmd.ea_add_x ? x_reg : y_reg;
    assign ea_sum  = {1'b0, tmp_reg} + {9'd0, add_idx};

    // all modes take the operand from the read register; for immediate modes it holds the fetched operand byte
    assign ld_val = rdata_reg;
    assign sum = {1'b0, acc_reg} + {1'b0, ld_val} + {8'd0, flag_reg[0]};

    always_comb begin
        nflags = flag_reg;
        if (op_reg == OP_ADC_IMM || op_reg == OP_ADC_ZP || op_reg == OP_ADC_ABS) begin
            nflags[0] = sum[8];
            nflags[6] = ~(acc_reg[7] ^ ld_val[7]) & (acc_reg[7] ^ sum[7]);
            nflags[1] = (sum[7:0] == 8'd0);
            nflags[7] = sum[7];
        end else begin
            nflags[1] = (ld_val == 8'd0);
            nflags[7] = ld_val[7];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg  <= 8'd0;
            x_reg    <= 8'd0;
            flag_reg <= 8'd0;
            y_reg    <= 8'd0;
            pc_reg   <= 16'd0;
        end else begin
            if (cfg_wr) begin
                if (cfg_idx == CFG_START) pc_reg <= cfg_val;
                else y_reg <= cfg_val[7:0];
            end else if (cmd.pc_inc) begin
                pc_reg <= pc_reg + 16'd1;
            end
            if (cmd.exec_wb) begin
                flag_reg <= nflags;
                if (op_reg == OP_LDX_IMM || op_reg == OP_LDX_ZP || op_reg == OP_LDX_ABS)
                    x_reg <= ld_val;
                else if (op_reg == OP_ADC_IMM || op_reg == OP_ADC_ZP
                         || op_reg == OP_ADC_ABS)
                    acc_reg <= sum[7:0];
                else
                    acc_reg <= ld_val;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op_load) op_reg <= rdata_reg;
        if (cmd.lo_load) tmp_reg[7:0] <= rdata_reg;
        if (cmd.hi_load) tmp_reg[15:8] <= rdata_reg;
        if (cmd.lo_add_x) tmp_reg[7:0] <= tmp_reg[7:0] + x_reg;
        if (cmd.ea_add_x || cmd.ea_add_y) begin
            tmp_reg  <= ea_sum[15:0];
            page_reg <= (ea_sum[15:8] != tmp_reg[15:8]);
        end
        if (cmd.rd_cap) rdv_reg <= rdata_reg;
        if (cmd.out_load)
            res_reg <= {4'd0, cmd.err, (cmd.is_read ? rdv_reg : 8'd0), cmd.cyc,
                        pc_reg, flag_reg, x_reg, acc_reg};
    end

    assign stat.opcode = op_reg;
    assign stat.page_x = page_reg;
    assign result = res_reg;

endmodule

>>> rtl/m65_ctrl.sv
//------------------------------------------------------------------------------
// m65_ctrl
// Sequencer: one memory access per step, then result handoff.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module m65_ctrl
    import m65_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] in_cmd,
    output logic       out_valid,
    input  logic       out_ready,
    input  m65_stat_t  stat,
    output m65_cmd_t   cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RDW   = 4'd1;  // read command data returns
    localparam logic [3:0] S_OP    = 4'd2;  // opcode returns
    localparam logic [3:0] S_B1    = 4'd3;  // first operand returns, decode
    localparam logic [3:0] S_B2    = 4'd4;  // issue second operand read
    localparam logic [3:0] S_B2W   = 4'd5;  // second operand returns
    localparam logic [3:0] S_ZPX   = 4'd6;  // zero page index add
    localparam logic [3:0] S_ZRD   = 4'd7;  // issue zero page read
    localparam logic [3:0] S_PLO   = 4'd8;  // pointer low returns
    localparam logic [3:0] S_PHI   = 4'd9;  // pointer high returns
    localparam logic [3:0] S_IDX   = 4'd10; // indexed add on word
    localparam logic [3:0] S_DRD   = 4'd11; // issue data read at word
    localparam logic [3:0] S_DAT   = 4'd12; // data byte returns
    localparam logic [3:0] S_DONE  = 4'd13; // build result
    localparam logic [3:0] S_OUT   = 4'd14;

    logic [3:0] state_reg, state_next;
    logic [2:0] cyc_reg, cyc_next;
    logic       err_reg, err_next;
    logic       rd_reg, rd_next;
    logic [7:0] op;
    logic       op_ind;
    logic       op_abi;

    assign op = stat.opcode;
    assign op_ind = (op == OP_LDA_INX) || (op == OP_LDA_INY);
    assign op_abi = (op == OP_LDA_ABX) || (op == OP_LDA_ABY);
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    always_comb begin
        state_next = state_reg;
        cyc_next = cyc_reg;
        err_next = err_reg;
        rd_next = rd_reg;
        cmd = '0;
        cmd.addr_sel = AS_PC;
        cmd.cyc = cyc_reg;
        cmd.err = err_reg;
        cmd.is_read = rd_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    cyc_next = 3'd0; err_next = 1'b0; rd_next = 1'b0;
                    unique case (in_cmd)
                        CMD_WRITE: begin
                            cmd.mem_wr = 1'b1; cmd.addr_sel = AS_IN;
                            state_next = S_DONE;
                        end
                        CMD_EXEC: begin
                            cmd.mem_rd = 1'b1; cmd.pc_inc = 1'b1;
                            state_next = S_OP;
                        end
                        CMD_READ: begin
                            cmd.mem_rd = 1'b1; cmd.addr_sel = AS_IN;
                            rd_next = 1'b1; state_next = S_RDW;
                        end
                        default: state_next = S_DONE;
                    endcase
                end
            end
            S_RDW: begin
                cmd.rd_cap = 1'b1; state_next = S_DONE;
            end
            S_OP: begin
                // read the byte after the opcode; pc moves only once decoded
                cmd.op_load = 1'b1; cmd.mem_rd = 1'b1;
                state_next = S_B1;
            end
            S_B1: begin
                unique case (op) inside
                    OP_LDA_IMM, OP_LDX_IMM, OP_ADC_IMM: begin
                        cmd.pc_inc = 1'b1; cmd.exec_wb = 1'b1;
                        cyc_next = 3'd2; state_next = S_DONE;
                    end
                    OP_LDA_ZP, OP_LDX_ZP, OP_ADC_ZP: begin
                        cmd.pc_inc = 1'b1; cmd.lo_load = 1'b1;
                        cyc_next = 3'd3; state_next = S_ZRD;
                    end
                    OP_LDA_ZPX: begin
                        cmd.pc_inc = 1'b1; cmd.lo_load = 1'b1;
                        cyc_next = 3'd4; state_next = S_ZPX;
                    end
                    OP_LDA_INX: begin
                        cmd.pc_inc = 1'b1; cmd.lo_load = 1'b1;
                        cyc_next = 3'd6; state_next = S_ZPX;
                    end
                    OP_LDA_INY: begin
                        cmd.pc_inc = 1'b1; cmd.lo_load = 1'b1;
                        cyc_next = 3'd5; state_next = S_ZRD;
                    end
                    OP_LDA_ABS, OP_LDX_ABS, OP_ADC_ABS, OP_LDA_ABX, OP_LDA_ABY: begin
                        cmd.pc_inc = 1'b1; cmd.lo_load = 1'b1;
                        cyc_next = 3'd4; state_next = S_B2;
                    end
                    default: begin
                        // unknown opcode: pc already past the opcode byte only
                        err_next = 1'b1; state_next = S_DONE;
                    end
                endcase
            end
            S_B2: begin
                cmd.mem_rd = 1'b1; cmd.pc_inc = 1'b1;
                state_next = S_B2W;
            end
            S_B2W: begin
                cmd.hi_load = 1'b1;
                state_next = op_abi ? S_IDX : S_DRD;
            end
            S_ZPX: begin
                cmd.lo_add_x = 1'b1; state_next = S_ZRD;
            end
            S_ZRD: begin
                cmd.mem_rd = 1'b1; cmd.addr_sel = AS_ZP;
                state_next = op_ind ? S_PLO : S_DAT;
            end
            S_PLO: begin
                // pointer low lands in tmp low after the high byte read is issued
                cmd.mem_rd = 1'b1; cmd.addr_sel = AS_ZP1; cmd.lo_load = 1'b1;
                state_next = S_PHI;
            end
            S_PHI: begin
                cmd.hi_load = 1'b1;
                state_next = (op == OP_LDA_INY) ? S_IDX : S_DRD;
            end
            S_IDX: begin
                cmd.ea_add_x = (op == OP_LDA_ABX);
                cmd.ea_add_y = (op != OP_LDA_ABX);
                state_next = S_DRD;
            end
            S_DRD: begin
                cmd.mem_rd = 1'b1; cmd.addr_sel = AS_EA;
                state_next = S_DAT;
            end
            S_DAT: begin
                cmd.exec_wb = 1'b1; state_next = S_DONE;
                if (op_abi || op == OP_LDA_INY)
                    cyc_next = cyc_reg + {2'd0, stat.page_x};
            end
            S_DONE: begin
                cmd.out_load = 1'b1; state_next = S_OUT;
            end
            S_OUT: begin
                if (out_ready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cyc_reg <= 3'd0;
            err_reg <= 1'b0;
            rd_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cyc_reg <= cyc_next;
            err_reg <= err_next;
            rd_reg <= rd_next;
        end
    end

endmodule

>>> rtl/mos6502_load_add_executor_unit.sv
//------------------------------------------------------------------------------
// mos6502_load_add_executor_unit
// 6502 LDA/LDX/ADC subset with internal byte memory.
//------------------------------------------------------------------------------
// channel   | dir | payload
// s_axis    | in  | tdata {data, address, cmd}
// m_axis    | out | tdata {error, read_data, cycles, pc, flags, x, a}
// cfg       | in  | cfg_index, cfg_data
// Items are writes, reads and executes; an execute is shortest for the
// immediate modes and an unknown opcode, longest for the indirect modes;
// one memory read port, one byte a cycle.
// Reset: synchronous, active low; a, x, y, flags and sequencer state clear, pc to 0.
// One item at a time; input stalls until the result transfers, so m_axis
// back pressure also holds off the next item.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module mos6502_load_add_executor_unit
    import m65_pkg::*;
#(
    parameter int MEM_ADDR_BITS = MEM_ADDR_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // cmd[1:0], address[17:2], data[25:18]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // acc, x, flags, pc, cycles, read_data, error
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    m65_cmd_t  cmd;
    m65_stat_t stat;

    assign cfg_ready = 1'b1;

    m65_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_cmd(s_axis_tdata[1:0]),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .stat(stat), .cmd(cmd)
    );

    m65_datapath #(.MEM_ADDR_BITS(MEM_ADDR_BITS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat),
        .in_address(s_axis_tdata[17:2]), .in_data(s_axis_tdata[25:18]),
        .cfg_wr(cfg_valid), .cfg_idx(cfg_index), .cfg_val(cfg_data),
        .result(m_axis_tdata)
    );

endmodule

>>> rtl/m65_checker.sv
//------------------------------------------------------------------------------
// m65_checker
// Port-level checks of the executor.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module m65_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata
);
    `CHK_IMPL(a_excl, aclk, aresetn, m_axis_tvalid, !s_axis_tready)
    `CHK_NEXT(a_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `CHK_NEXT(a_stable, aclk, aresetn, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
    `CHK_NEXT(a_take, aclk, aresetn, s_axis_tvalid && s_axis_tready, !s_axis_tready)
endmodule

bind mos6502_load_add_executor_unit m65_checker u_chk (.*);
